// File: rtl/core/assert_macros.svh
// Assertion macros shared by the pressure sample conditioner RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check that a condition holds at every clock edge out of reset.
`define PSC_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("invariant violated");

// Check that a condition implies another one in the same cycle.
`define PSC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication violated");

// Check that a condition implies another one in the next cycle.
`define PSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sequence violated");

`else

`define PSC_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define PSC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define PSC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/core/psc_pkg.sv
// Shared types, widths and constants of the pressure sample conditioner.
`default_nettype none

package psc_pkg;

    // Field and register widths
    localparam int ADC_W      = 15;
    localparam int PRESS_W    = 16;
    localparam int BAR_W      = 4;
    localparam int WEIGHT_W   = 16;
    localparam int GAIN_W     = 24;
    localparam int AVG_W      = 24;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    // Default parameter values
    localparam int DEFAULT_BAR_COUNT   = 15;
    localparam int DEFAULT_SAMPLE_BITS = 15;

    // Register reset values
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(6554);
    localparam logic [GAIN_W-1:0]   GAIN_RESET   = GAIN_W'(97525);
    localparam logic [PRESS_W-1:0]  OFFSET_RESET = PRESS_W'(2679);
    localparam logic [PRESS_W-1:0]  LIMIT_RESET  = PRESS_W'(5120);

    // Unity weight, one past the largest Q0.16 weight
    localparam logic [WEIGHT_W:0] WEIGHT_ONE = (WEIGHT_W+1)'(1) << WEIGHT_W;

    // Configuration register index
    typedef enum logic [1:0] {
        REG_SMOOTHING_WEIGHT = 2'd0,
        REG_SCALE_GAIN       = 2'd1,
        REG_SCALE_OFFSET     = 2'd2,
        REG_PRESSURE_LIMIT   = 2'd3
    } reg_index_t;

    // Configuration register contents
    typedef struct packed {
        logic [WEIGHT_W-1:0] smoothing_weight;
        logic [GAIN_W-1:0]   scale_gain;
        logic [PRESS_W-1:0]  scale_offset;
        logic [PRESS_W-1:0]  pressure_limit;
    } cfg_t;

    // Status of a serial multiply-accumulate unit
    typedef struct packed {
        logic busy;
        logic done;
    } mac_status_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_AVG_MUL = 3'd1,
        ST_AVG_RND = 3'd2,
        ST_SCL_MUL = 3'd3,
        ST_SCL_RND = 3'd4,
        ST_FINISH  = 3'd5
    } state_t;

endpackage

`default_nettype wire

// File: rtl/core/pressure_sample_conditioner.sv
// A sample runs the averaging multiply, its rounding, the gain multiply, its rounding and the
// finish step; a clear goes straight to finish, which stalls while an untaken result is held.
// Only idle takes a new transaction; the multiplier runs 17 steps for averaging, 24 for gain.
// A finished result waits in the output register while the next transaction is taken.
// Reset (rst_n, asynchronous, active low) zeroes average, previous pressure, peak and bar level,
// and loads the register defaults.
`default_nettype none

module pressure_sample_conditioner #(
    parameter int BAR_COUNT   = psc_pkg::DEFAULT_BAR_COUNT,
    parameter int SAMPLE_BITS = psc_pkg::DEFAULT_SAMPLE_BITS
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             sample_valid,
    output logic                                  sample_ready,
    input  wire logic                             command,
    input  wire logic [psc_pkg::ADC_W-1:0]        adc_sample,
    output logic                                  result_valid,
    input  wire logic                             result_ready,
    output logic [psc_pkg::PRESS_W-1:0]           pressure,
    output logic [psc_pkg::PRESS_W-1:0]           peak_pressure,
    output logic                                  over_limit,
    output logic                                  peak_over_limit,
    output logic [psc_pkg::BAR_W-1:0]             bar_level,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [psc_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [psc_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [psc_pkg::CFG_DATA_W-1:0]        prdata,
    output logic                                  pready
);
    import psc_pkg::*;

`include "assert_macros.svh"

    localparam int FRAC_W    = AVG_W - SAMPLE_BITS;
    localparam int MB1_W     = WEIGHT_W + 1;
    localparam int P1_W      = AVG_W + MB1_W + 1;
    localparam int P2_W      = AVG_W + GAIN_W + 1;
    localparam int RND_POS   = 15 + FRAC_W;
    localparam int SCALED_W  = P2_W - RND_POS;
    localparam int TARGET_W  = PRESS_W - 9;
    localparam int CAP_INT   = (BAR_COUNT < 15) ? BAR_COUNT : 15;
    localparam logic [BAR_W-1:0] LEVEL_CAP   = BAR_W'(CAP_INT);
    localparam logic [AVG_W-1:0] SAMPLE_MASK = AVG_W'((64'd1 << SAMPLE_BITS) - 64'd1);

    cfg_t            cfg;
    mac_status_t     avg_status;
    mac_status_t     scl_status;
    state_t          state_reg;
    state_t          state_next;

    logic [P1_W-1:0] avg_product;
    logic [P2_W-1:0] scl_product;
    logic [AVG_W-1:0] sample_ext;
    logic [AVG_W-1:0] avg_a1;
    logic [AVG_W-1:0] avg_rnd;
    logic [MB1_W-1:0] weight_new;
    logic [MB1_W-1:0] weight_old;

    logic [SCALED_W-1:0] scaled;
    logic [SCALED_W-1:0] offset_ext;
    logic [SCALED_W-1:0] diff;
    logic [PRESS_W-1:0]  p_calc;

    logic [AVG_W-1:0]   average_reg;
    logic [PRESS_W-1:0] prev_reg;
    logic [PRESS_W-1:0] peak_reg;
    logic [BAR_W-1:0]   lit_bars_reg;
    logic [PRESS_W-1:0] p_work_reg;
    logic               clear_reg;

    logic [PRESS_W-1:0] res_p;
    logic [PRESS_W-1:0] peak_next;
    logic [PRESS_W-1:0] prev_next;
    logic [BAR_W-1:0]   lit_bars_next;
    logic [TARGET_W-1:0] target_raw;
    logic [BAR_W-1:0]   target;

    logic [PRESS_W-1:0] pressure_reg;
    logic [PRESS_W-1:0] peak_pressure_reg;
    logic               over_limit_reg;
    logic               peak_over_limit_reg;
    logic [BAR_W-1:0]   bar_level_reg;
    logic               result_valid_reg;

    logic sample_accept;
    logic avg_start;
    logic scl_start;
    logic avg_load;
    logic p_load;
    logic finish_load;

    // Configuration registers
    psc_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Prepare the averaging operands
    assign sample_ext = AVG_W'(adc_sample) & SAMPLE_MASK;
    assign avg_a1     = sample_ext << FRAC_W;
    assign weight_new = MB1_W'(cfg.smoothing_weight);
    assign weight_old = WEIGHT_ONE - weight_new;

    psc_serial_mac #(
        .A_W (AVG_W),
        .B_W (MB1_W)
    ) u_avg_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (avg_start),
        .a1      (avg_a1),
        .a2      (average_reg),
        .b1      (weight_new),
        .b2      (weight_old),
        .product (avg_product),
        .status  (avg_status)
    );

    // Round the weighted sum to the new average
    assign avg_rnd = avg_product[16 +: AVG_W] + AVG_W'(avg_product[15]);

    psc_serial_mac #(
        .A_W (AVG_W),
        .B_W (GAIN_W)
    ) u_scl_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (scl_start),
        .a1      (avg_rnd),
        .a2      ('0),
        .b1      (cfg.scale_gain),
        .b2      ('0),
        .product (scl_product),
        .status  (scl_status)
    );

    // Round the scaled value, remove the offset, clamp and saturate
    always_comb
    begin
        scaled     = SCALED_W'(scl_product[P2_W-1:RND_POS+1]) + SCALED_W'(scl_product[RND_POS]);
        offset_ext = SCALED_W'(cfg.scale_offset);
        diff       = scaled - offset_ext;
        if (scaled <= offset_ext)
        begin
            p_calc = '0;
        end
        else if (diff[SCALED_W-1:PRESS_W] != '0)
        begin
            p_calc = '1;
        end
        else
        begin
            p_calc = diff[PRESS_W-1:0];
        end
    end

    // Work out the result and the state updates
    always_comb
    begin
        target_raw = p_work_reg[PRESS_W-1:9];
        target     = (target_raw > TARGET_W'(LEVEL_CAP)) ? LEVEL_CAP : target_raw[BAR_W-1:0];
        if (clear_reg)
        begin
            res_p         = prev_reg;
            peak_next     = '0;
            prev_next     = prev_reg;
            lit_bars_next = lit_bars_reg;
        end
        else
        begin
            res_p         = p_work_reg;
            prev_next     = p_work_reg;
            peak_next     = (p_work_reg > peak_reg) ? p_work_reg : peak_reg;
            lit_bars_next = lit_bars_reg;
            if (p_work_reg > prev_reg)
            begin
                if (target > lit_bars_reg)
                begin
                    lit_bars_next = target;
                end
            end
            else if (p_work_reg < prev_reg)
            begin
                if (target < lit_bars_reg)
                begin
                    lit_bars_next = target;
                end
            end
        end
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    state_next = command ? ST_FINISH : ST_AVG_MUL;
                end
            end
            ST_AVG_MUL:
            begin
                if (avg_status.done)
                begin
                    state_next = ST_AVG_RND;
                end
            end
            ST_AVG_RND:
            begin
                state_next = ST_SCL_MUL;
            end
            ST_SCL_MUL:
            begin
                if (scl_status.done)
                begin
                    state_next = ST_SCL_RND;
                end
            end
            ST_SCL_RND:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        sample_ready = 1'b0;
        avg_start    = 1'b0;
        scl_start    = 1'b0;
        avg_load     = 1'b0;
        p_load       = 1'b0;
        finish_load  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                sample_ready = 1'b1;
                avg_start    = sample_valid && !command;
            end
            ST_AVG_RND:
            begin
                scl_start = 1'b1;
                avg_load  = 1'b1;
            end
            ST_SCL_RND:
            begin
                p_load = 1'b1;
            end
            ST_FINISH:
            begin
                finish_load = !result_valid_reg || result_ready;
            end
            default:
            begin
                sample_ready = 1'b0;
            end
        endcase
    end

    assign sample_accept = sample_valid && sample_ready;

    // Sequencer and block state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            clear_reg    <= 1'b0;
            average_reg  <= '0;
            prev_reg     <= '0;
            peak_reg     <= '0;
            lit_bars_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (sample_accept)
            begin
                clear_reg <= command;
            end
            if (avg_load)
            begin
                average_reg <= avg_rnd;
            end
            if (finish_load)
            begin
                prev_reg     <= prev_next;
                peak_reg     <= peak_next;
                lit_bars_reg <= lit_bars_next;
            end
        end
    end

    // Hold the computed pressure until the finish step
    always_ff @(posedge clk)
    begin
        if (p_load)
        begin
            p_work_reg <= p_calc;
        end
    end

    // Output register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (finish_load)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (finish_load)
        begin
            pressure_reg        <= res_p;
            peak_pressure_reg   <= peak_next;
            over_limit_reg      <= (res_p > cfg.pressure_limit);
            peak_over_limit_reg <= (peak_next > cfg.pressure_limit);
            bar_level_reg       <= lit_bars_next;
        end
    end

    assign result_valid    = result_valid_reg;
    assign pressure        = pressure_reg;
    assign peak_pressure   = peak_pressure_reg;
    assign over_limit      = over_limit_reg;
    assign peak_over_limit = peak_over_limit_reg;
    assign bar_level       = bar_level_reg;

    // Checks
    `PSC_ASSERT_ALWAYS(a_bar_cap, clk, rst_n, lit_bars_reg <= LEVEL_CAP)
    `PSC_ASSERT_IMPLIES(a_avg_busy, clk, rst_n, avg_status.busy, state_reg == ST_AVG_MUL)
    `PSC_ASSERT_IMPLIES(a_scl_busy, clk, rst_n, scl_status.busy, state_reg == ST_SCL_MUL)
    `PSC_ASSERT_NEXT(a_out_load, clk, rst_n, !result_valid_reg && state_reg != ST_FINISH, !result_valid_reg)

endmodule

`default_nettype wire

// File: rtl/core/psc_serial_mac.sv
// Bit-serial multiply-accumulate unit: a1*b1 + a2*b2, one multiplier bit per cycle.
`default_nettype none

module psc_serial_mac #(
    parameter int A_W = 24,
    parameter int B_W = 17
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [A_W-1:0]       a1,
    input  wire logic [A_W-1:0]       a2,
    input  wire logic [B_W-1:0]       b1,
    input  wire logic [B_W-1:0]       b2,
    output logic [A_W+B_W:0]          product,
    output psc_pkg::mac_status_t      status
);
    import psc_pkg::*;

    localparam int P_W   = A_W + B_W + 1;
    localparam int CNT_W = $clog2(B_W);

    logic [A_W-1:0]   a1_reg;
    logic [A_W-1:0]   a2_reg;
    logic [B_W-1:0]   b1_reg;
    logic [B_W-1:0]   b2_reg;
    logic [P_W-1:0]   acc_reg;
    logic [P_W-1:0]   acc_next;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic             last_step;
    logic [A_W-1:0]   add1;
    logic [A_W-1:0]   add2;
    logic [A_W+1:0]   sum;

    // Add the selected multiplicands into the upper part and shift right
    always_comb
    begin
        add1     = b1_reg[0] ? a1_reg : '0;
        add2     = b2_reg[0] ? a2_reg : '0;
        sum      = (A_W+2)'(acc_reg[P_W-1:B_W]) + (A_W+2)'(add1) + (A_W+2)'(add2);
        acc_next = {sum, acc_reg[B_W-1:1]};
    end

    assign last_step = (cnt_reg == CNT_W'(B_W-1));

    // Step counter and status flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && last_step;
            if (start)
            begin
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Operand and accumulator shift registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a1_reg  <= a1;
            a2_reg  <= a2;
            b1_reg  <= b1;
            b2_reg  <= b2;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            b1_reg  <= b1_reg >> 1;
            b2_reg  <= b2_reg >> 1;
            acc_reg <= acc_next;
        end
    end

    assign product     = acc_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

`default_nettype wire

// File: rtl/core/psc_cfg_regs.sv
// APB configuration registers of the pressure sample conditioner.
`default_nettype none

module psc_cfg_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [psc_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [psc_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [psc_pkg::CFG_DATA_W-1:0]        prdata,
    output logic                                  pready,
    output psc_pkg::cfg_t                         cfg
);
    import psc_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    reg_index_t index;
    logic       wr_en;

    assign index = reg_index_t'(paddr[CFG_ADDR_W-1:2]);
    assign wr_en = psel && penable && pwrite;

    // Decode the write transaction
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (index)
                REG_SMOOTHING_WEIGHT: cfg_next.smoothing_weight = pwdata[WEIGHT_W-1:0];
                REG_SCALE_GAIN:       cfg_next.scale_gain       = pwdata[GAIN_W-1:0];
                REG_SCALE_OFFSET:     cfg_next.scale_offset     = pwdata[PRESS_W-1:0];
                REG_PRESSURE_LIMIT:   cfg_next.pressure_limit   = pwdata[PRESS_W-1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the register values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.smoothing_weight <= WEIGHT_RESET;
            cfg_reg.scale_gain       <= GAIN_RESET;
            cfg_reg.scale_offset     <= OFFSET_RESET;
            cfg_reg.pressure_limit   <= LIMIT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Return the addressed register on a read
    always_comb
    begin
        case (index)
            REG_SMOOTHING_WEIGHT: prdata = CFG_DATA_W'(cfg_reg.smoothing_weight);
            REG_SCALE_GAIN:       prdata = CFG_DATA_W'(cfg_reg.scale_gain);
            REG_SCALE_OFFSET:     prdata = CFG_DATA_W'(cfg_reg.scale_offset);
            REG_PRESSURE_LIMIT:   prdata = CFG_DATA_W'(cfg_reg.pressure_limit);
            default:              prdata = '0;
        endcase
    end

    assign pready = 1'b1;
    assign cfg    = cfg_reg;

endmodule

`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the pressure sample conditioner with directed and random traffic.
`timescale 1ns / 100ps

module testbench;
    import psc_pkg::*;

    localparam int AVG_FRAC          = AVG_W - DEFAULT_SAMPLE_BITS;
    localparam int LEVEL_CAP         = (DEFAULT_BAR_COUNT < 15) ? DEFAULT_BAR_COUNT : 15;
    localparam int STALL_LIMIT       = 2000;
    localparam int SETTLE_CYCLES     = 64;
    localparam int ITEMS_PER_SETTING = 150;
    localparam int PHASE_ITEMS       = 600;
    localparam int REPORT_MAX        = 10;

    // Command codes of the input transaction
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    typedef struct packed {
        logic [PRESS_W-1:0] press;
        logic [PRESS_W-1:0] peak;
        logic               over;
        logic               peak_over;
        logic [BAR_W-1:0]   bars;
    } reading_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  sample_valid;
    logic                  sample_ready;
    logic                  command;
    logic [ADC_W-1:0]      adc_sample;
    logic                  result_valid;
    logic                  result_ready;
    logic [PRESS_W-1:0]    pressure;
    logic [PRESS_W-1:0]    peak_pressure;
    logic                  over_limit;
    logic                  peak_over_limit;
    logic [BAR_W-1:0]      bar_level;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // Predictor copy of the registers and the filter state
    cfg_t               cfg_shadow;
    logic [AVG_W-1:0]   avg_model;
    logic [PRESS_W-1:0] last_pressure;
    logic [PRESS_W-1:0] peak_hold;
    logic [BAR_W-1:0]   bars_lit;
    reading_t           pending_readings[$];

    int mismatch_count   = 0;
    int stall_cycles     = 0;
    int send_idle_pct    = 0;
    int recv_idle_pct    = 0;
    int samples_sent     = 0;
    int clears_sent      = 0;
    int settings_applied = 0;
    int readings_checked = 0;
    int trend_level      = 16384;
    int trend_step       = 200;

    pressure_sample_conditioner u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .sample_valid    (sample_valid),
        .sample_ready    (sample_ready),
        .command         (command),
        .adc_sample      (adc_sample),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .pressure        (pressure),
        .peak_pressure   (peak_pressure),
        .over_limit      (over_limit),
        .peak_over_limit (peak_over_limit),
        .bar_level       (bar_level),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #2 clk = ~clk;

    // Advance the filter model by one transaction and return the expected result
    function automatic reading_t predict_reading(input logic cmd, input logic [ADC_W-1:0] adc);
        longint unsigned    w;
        longint unsigned    acc;
        longint unsigned    prod;
        longint unsigned    scaled;
        longint unsigned    off;
        logic [PRESS_W-1:0] p;
        logic [BAR_W-1:0]   target;
        reading_t           r;

        if (cmd == CMD_CLEAR)
        begin
            peak_hold = '0;
            p = last_pressure;
        end
        else
        begin
            // Blend the new sample into the average, rounding half up
            w = 64'(cfg_shadow.smoothing_weight);
            acc = ((64'(adc) << AVG_FRAC) * w) + (64'(avg_model) * (64'd65536 - w)) + 64'd32768;
            avg_model = AVG_W'(acc >> 16);

            // Scale to pressure, then clamp at zero and saturate at the top
            prod = 64'(avg_model) * 64'(cfg_shadow.scale_gain);
            scaled = (prod + (64'd1 << (15 + AVG_FRAC))) >> (16 + AVG_FRAC);
            off = 64'(cfg_shadow.scale_offset);
            if (scaled <= off)
                p = '0;
            else if (scaled - off > 64'hFFFF)
                p = '1;
            else
                p = PRESS_W'(scaled - off);

            // Let the bar level follow only in the direction the pressure moves
            if ((p >> 9) > LEVEL_CAP)
                target = BAR_W'(LEVEL_CAP);
            else
                target = BAR_W'(p >> 9);
            if (p > last_pressure && target > bars_lit)
                bars_lit = target;
            else if (p < last_pressure && target < bars_lit)
                bars_lit = target;

            if (p > peak_hold)
                peak_hold = p;
            last_pressure = p;
        end

        r.press     = p;
        r.peak      = peak_hold;
        r.over      = p > cfg_shadow.pressure_limit;
        r.peak_over = peak_hold > cfg_shadow.pressure_limit;
        r.bars      = bars_lit;
        return r;
    endfunction

    // Drive one input transaction, hold it until taken, then record its expected result
    task automatic send_sample(input logic cmd, input logic [ADC_W-1:0] adc);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(negedge clk);
        end
        sample_valid <= 1'b1;
        command      <= cmd;
        adc_sample   <= adc;
        do
            @(posedge clk);
        while (!(sample_valid && sample_ready));
        pending_readings.push_back(predict_reading(cmd, adc));
        if (cmd == CMD_CLEAR)
            clears_sent++;
        else
            samples_sent++;
    endtask

    // Drop valid and hold until every expected result has been checked
    task automatic wait_for_readings();
        @(negedge clk);
        sample_valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
    endtask

    // Write one register through a setup and an access cycle
    task automatic write_register(input reg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(idx) << 2;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!(psel && penable && pwrite && pready));
        case (idx)
            REG_SMOOTHING_WEIGHT: cfg_shadow.smoothing_weight = value[WEIGHT_W-1:0];
            REG_SCALE_GAIN:       cfg_shadow.scale_gain       = value[GAIN_W-1:0];
            REG_SCALE_OFFSET:     cfg_shadow.scale_offset     = value[PRESS_W-1:0];
            REG_PRESSURE_LIMIT:   cfg_shadow.pressure_limit   = value[PRESS_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_settings(input logic [WEIGHT_W-1:0] weight, input logic [GAIN_W-1:0] gain,
                                  input logic [PRESS_W-1:0] offset, input logic [PRESS_W-1:0] limit);
        write_register(REG_SMOOTHING_WEIGHT, CFG_DATA_W'(weight));
        write_register(REG_SCALE_GAIN, CFG_DATA_W'(gain));
        write_register(REG_SCALE_OFFSET, CFG_DATA_W'(offset));
        write_register(REG_PRESSURE_LIMIT, CFG_DATA_W'(limit));
        settings_applied++;
    endtask

    // Choose a register set: mostly realistic, now and then an extreme
    task automatic pick_random_settings();
        case ($urandom_range(0, 9))
            0: apply_settings('0, '0, '0, '0);
            1: apply_settings('1, '1, '1, '1);
            2: apply_settings('1, GAIN_W'($urandom_range(20000, 400000)), '0,
                              PRESS_W'($urandom()));
            3: apply_settings(WEIGHT_W'($urandom()), GAIN_W'($urandom()), PRESS_W'($urandom()),
                              PRESS_W'($urandom()));
            default: apply_settings(WEIGHT_W'($urandom_range(4096, 65535)),
                                    GAIN_W'($urandom_range(20000, 400000)),
                                    PRESS_W'($urandom_range(0, 12000)),
                                    PRESS_W'($urandom_range(0, 20000)));
        endcase
    endtask

    // Produce ramps, holds and reversals with noise, plus stray samples and clears
    task automatic next_random_item(output logic cmd, output logic [ADC_W-1:0] adc);
        int pick;
        int noise;
        int level;

        pick = $urandom_range(0, 99);
        cmd = CMD_SAMPLE;
        adc = ADC_W'($urandom());
        if (pick < 8)
            cmd = CMD_CLEAR;
        else if (pick >= 22)
        begin
            if ($urandom_range(0, 19) == 0)
                trend_step = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 2400)) - 1200;
            trend_level += trend_step;
            if (trend_level < 0)
            begin
                trend_level = 0;
                trend_step = -trend_step;
            end
            else if (trend_level > 32767)
            begin
                trend_level = 32767;
                trend_step = -trend_step;
            end
            noise = ($urandom_range(0, 1) == 0) ? 0 : int'($urandom_range(0, 64)) - 32;
            level = trend_level + noise;
            if (level < 0 || level > 32767)
                level = trend_level;
            adc = ADC_W'(level);
        end
    endtask

    // Default registers: both sample extremes, rise, fall, repeat and clears
    task automatic test_reset_defaults();
        send_sample(CMD_SAMPLE, '0);
        repeat (3) send_sample(CMD_SAMPLE, '1);
        repeat (2) send_sample(CMD_SAMPLE, ADC_W'(16384));
        repeat (2) send_sample(CMD_CLEAR, '0);
        repeat (2) send_sample(CMD_SAMPLE, '0);
        wait_for_readings();
    endtask

    // Full weight and largest gain: saturate pressure and bars, then fall away
    task automatic test_full_weight_saturation();
        apply_settings('1, '1, '0, '0);
        repeat (2) send_sample(CMD_SAMPLE, '1);
        send_sample(CMD_SAMPLE, '0);
        send_sample(CMD_CLEAR, '1);
        wait_for_readings();
    endtask

    // Zero weight and gain with the largest offset: pressure pinned at zero
    task automatic test_offset_above_scaled();
        apply_settings('0, '0, '1, '1);
        send_sample(CMD_SAMPLE, ADC_W'(100));
        send_sample(CMD_SAMPLE, '1);
        send_sample(CMD_CLEAR, '0);
        wait_for_readings();
    endtask

    // Random traffic in blocks, each block under a fresh register set
    task automatic test_random_traffic(input int send_pct, input int recv_pct);
        logic             cmd;
        logic [ADC_W-1:0] adc;

        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int n = 0; n < PHASE_ITEMS; n++)
        begin
            if (n % ITEMS_PER_SETTING == 0)
            begin
                wait_for_readings();
                pick_random_settings();
            end
            next_random_item(cmd, adc);
            send_sample(cmd, adc);
        end
        wait_for_readings();
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
                $display("mismatch on %s at %0t: expected %0d, got %0d", name, $realtime, exp_v,
                         act_v);
        end
    endtask

    // Randomize result ready each cycle
    always @(negedge clk)
        result_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // Compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin
        reading_t observed;
        reading_t predicted;

        if (rst_n && result_valid && result_ready)
        begin
            observed = '{pressure, peak_pressure, over_limit, peak_over_limit, bar_level};
            if (pending_readings.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("result with nothing pending at %0t: pressure %0d", $realtime,
                             observed.press);
            end
            else
            begin
                predicted = pending_readings.pop_front();
                readings_checked++;
                check_field("pressure", 32'(predicted.press), 32'(observed.press));
                check_field("peak_pressure", 32'(predicted.peak), 32'(observed.peak));
                check_field("over_limit", 32'(predicted.over), 32'(observed.over));
                check_field("peak_over_limit", 32'(predicted.peak_over),
                            32'(observed.peak_over));
                check_field("bar_level", 32'(predicted.bars), 32'(observed.bars));
            end
        end
    end

    // Stop the run when no transaction moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (sample_valid && sample_ready) || (result_valid && result_ready) ||
            (psel && penable))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("no transaction for %0d cycles at %0t", stall_cycles, $realtime);
            $display("FAIL");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        // Drive every input and load the reset state of the model
        rst_n        = 1'b0;
        sample_valid = 1'b0;
        command      = CMD_SAMPLE;
        adc_sample   = '0;
        result_ready = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        cfg_shadow.smoothing_weight = WEIGHT_RESET;
        cfg_shadow.scale_gain       = GAIN_RESET;
        cfg_shadow.scale_offset     = OFFSET_RESET;
        cfg_shadow.pressure_limit   = LIMIT_RESET;
        avg_model     = '0;
        last_pressure = '0;
        peak_hold     = '0;
        bars_lit      = '0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_full_weight_saturation();
        test_offset_above_scaled();
        test_random_traffic(20, 88);
        test_random_traffic(88, 20);
        test_random_traffic(0, 0);

        // Let any stray result show up before the verdict
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_readings.size() != 0)
        begin
            $display("%0d expected results never arrived", pending_readings.size());
            mismatch_count += pending_readings.size();
        end

        $display("Covered %0d samples and %0d peak clears; %0d results compared field by field",
                 samples_sent, clears_sent, readings_checked);
        $display("under %0d register sets, from all-zero to all-ones, with idle and stall mixes",
                 settings_applied);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/psc_pkg.sv
rtl/core/psc_serial_mac.sv
rtl/core/psc_cfg_regs.sv
rtl/core/pressure_sample_conditioner.sv
tb/testbench.sv
